@@ sv/gpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// gpmc_pkg
// Shared types and constants for the genotype pair mismatch counter.
// ----------------------------------------------------------------------------
package gpmc_pkg;

	localparam int ROW_W     = 10;
	localparam int CODE_W    = 8;
	localparam int CNT_W     = 17;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;

	// flag store never needs more entries than a row index can address
	localparam int ROW_SLOTS = 1 << ROW_W;

	// largest value a 17-bit counter holds
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [CODE_W-1:0]    code_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DIFF       = 3'd0,
		REG_COMPARE_MODE   = 3'd1,
		REG_MISSING_CODE   = 3'd2,
		REG_HET_CODE       = 3'd3,
		REG_ONE_MATCH_ONLY = 3'd4
	} cfg_reg_t;

	// compare modes; other codes count no mismatches
	localparam mode_t MODE_ANY = 2'd0;
	localparam mode_t MODE_HET = 2'd1;

	// register reset values
	localparam cnt_t  RST_MAX_DIFF     = 17'd1;
	localparam mode_t RST_COMPARE_MODE = MODE_ANY;
	localparam code_t RST_MISSING_CODE = 8'd0;
	localparam code_t RST_HET_CODE     = 8'd2;

	// write request into a flag store
	typedef struct packed {
		logic en;
		row_t addr;
		logic value;
	} flag_wr_t;

endpackage

@@ sv/gpmc_if.sv @@
// ----------------------------------------------------------------------------
// gpmc interfaces
// Valid/ready channels for column requests, pair results and register writes.
// ----------------------------------------------------------------------------

// one column of a row pair
interface gpmc_item_if;
	logic            valid;
	logic            ready;
	gpmc_pkg::row_t  x_row;
	gpmc_pkg::row_t  y_row;
	gpmc_pkg::code_t x_code;
	gpmc_pkg::code_t y_code;
	logic            last_column;

	modport source (output valid, x_row, y_row, x_code, y_code, last_column, input ready);
	modport sink   (input valid, x_row, y_row, x_code, y_code, last_column, output ready);
endinterface

// one accepted row pair
interface gpmc_result_if;
	logic           valid;
	logic           ready;
	gpmc_pkg::row_t match_x_row;
	gpmc_pkg::row_t match_y_row;
	gpmc_pkg::cnt_t mismatches;
	gpmc_pkg::cnt_t compared;

	modport source (output valid, match_x_row, match_y_row, mismatches, compared,
		input ready);
	modport sink   (input valid, match_x_row, match_y_row, mismatches, compared,
		output ready);
endinterface

// register write
interface gpmc_cfg_if;
	logic               valid;
	logic               ready;
	gpmc_pkg::cfg_idx_t index;
	gpmc_pkg::cfg_dat_t data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/gpmc_flag_mem.sv @@
// ----------------------------------------------------------------------------
// gpmc_flag_mem
// One-bit-wide row flag store with a registered read port and one write port.
// ----------------------------------------------------------------------------
module gpmc_flag_mem #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               rd_en,
	input  gpmc_pkg::row_t     rd_addr,
	output logic               rd_data,
	input  gpmc_pkg::flag_wr_t wr
);
	import gpmc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic mem_q [DEPTH];
	logic rd_data_q;

	logic rd_hit;
	logic wr_hit;

	// addresses beyond the store are never written and read as clear
	assign rd_hit = ({22'd0, rd_addr} < 32'(DEPTH));
	assign wr_hit = ({22'd0, wr.addr} < 32'(DEPTH));

	// write port
	always_ff @(posedge clk) begin
		if (wr.en && wr_hit) begin
			mem_q[wr.addr[AW-1:0]] <= wr.value;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rd_hit ? mem_q[rd_addr[AW-1:0]] : 1'b0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/genotype_pair_mismatch_counter_core.sv @@
// ----------------------------------------------------------------------------
// genotype_pair_mismatch_counter_core
// Masked Hamming distance over a streamed row pair with one-match row flags.
// ----------------------------------------------------------------------------
// path: last column request -> column stage -> result register -> result
// throughput: one column request per cycle; the stage and output register
//   advance together, so only a held result or the clearing sweep stalls the input
// reset: after arst_n releases, both flag stores are swept clear, one row per
//   cycle, over max(min(X_ROWS,1024), min(Y_ROWS,1024)) rows with item.ready low
module genotype_pair_mismatch_counter_core #(
	parameter int X_ROWS      = 1024,
	parameter int Y_ROWS      = 1024,
	parameter int MAX_COLUMNS = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	gpmc_item_if.sink     item,
	gpmc_result_if.source result,
	gpmc_cfg_if.sink      cfg
);
	import gpmc_pkg::*;

	localparam int X_DEPTH = (X_ROWS < ROW_SLOTS) ? X_ROWS : ROW_SLOTS;
	localparam int Y_DEPTH = (Y_ROWS < ROW_SLOTS) ? Y_ROWS : ROW_SLOTS;
	localparam int CLR_LEN = (X_DEPTH > Y_DEPTH) ? X_DEPTH : Y_DEPTH;
	localparam row_t CLR_LAST = ROW_W'(CLR_LEN - 1);
	localparam cnt_t CMP_LIMIT = CNT_W'((MAX_COLUMNS < CNT_MAX) ? MAX_COLUMNS : CNT_MAX);

	// configuration registers
	cnt_t  max_diff_q;
	mode_t compare_mode_q;
	code_t missing_code_q;
	code_t het_code_q;
	logic  one_match_only_q;

	// clearing sweep
	logic clr_active_q;
	row_t clr_idx_q;

	// column stage
	logic  valid_s1;
	row_t  x_row_s1;
	row_t  y_row_s1;
	code_t x_code_s1;
	code_t y_code_s1;
	logic  last_s1;
	logic  x_fwd_s1;
	logic  y_fwd_s1;

	// running counts of the current pair
	cnt_t compared_q;
	cnt_t mismatch_q;

	// result register
	logic out_valid_q;
	row_t out_x_q;
	row_t out_y_q;
	cnt_t out_mis_q;
	cnt_t out_cmp_q;

	logic     item_fire;
	logic     out_free;
	logic     advance;
	logic     called;
	logic     diff;
	cnt_t     compared_new;
	cnt_t     mismatch_new;
	logic     in_range;
	logic     x_flag_rd;
	logic     y_flag_rd;
	logic     x_flagged;
	logic     y_flagged;
	logic     emit;
	logic     flag_set;
	flag_wr_t x_wr;
	flag_wr_t y_wr;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_diff_q       <= RST_MAX_DIFF;
			compare_mode_q   <= RST_COMPARE_MODE;
			missing_code_q   <= RST_MISSING_CODE;
			het_code_q       <= RST_HET_CODE;
			one_match_only_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_DIFF:       max_diff_q       <= cfg.data;
				REG_COMPARE_MODE:   compare_mode_q   <= cfg.data[MODE_W-1:0];
				REG_MISSING_CODE:   missing_code_q   <= cfg.data[CODE_W-1:0];
				REG_HET_CODE:       het_code_q       <= cfg.data[CODE_W-1:0];
				REG_ONE_MATCH_ONLY: one_match_only_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// sweep both flag stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == CLR_LAST) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// handshake
	assign out_free   = !out_valid_q || result.ready;
	assign advance    = valid_s1 && (!emit || out_free);
	assign item.ready = !clr_active_q && (!valid_s1 || advance);
	assign item_fire  = item.valid && item.ready;

	// column comparison and count update
	always_comb begin
		called = (x_code_s1 != missing_code_q) && (y_code_s1 != missing_code_q);
		unique case (compare_mode_q)
			MODE_ANY: diff = x_code_s1 != y_code_s1;
			MODE_HET: diff = (x_code_s1 == het_code_q) != (y_code_s1 == het_code_q);
			default:  diff = 1'b0;
		endcase
		compared_new = compared_q;
		mismatch_new = mismatch_q;
		if (called && (compared_q < CMP_LIMIT)) begin
			compared_new = compared_q + 1'b1;
		end
		if (called && diff && (mismatch_q < max_diff_q)) begin
			mismatch_new = mismatch_q + 1'b1;
		end
	end

	// pair decision on the last column
	assign in_range  = ({22'd0, x_row_s1} < 32'(X_ROWS)) && ({22'd0, y_row_s1} < 32'(Y_ROWS));
	assign x_flagged = x_flag_rd || x_fwd_s1;
	assign y_flagged = y_flag_rd || y_fwd_s1;
	assign emit      = last_s1 && in_range && (mismatch_new < max_diff_q) &&
		!x_flagged && !y_flagged;
	assign flag_set  = advance && emit && one_match_only_q;

	// flag store writes: clearing sweep or match flags
	always_comb begin
		if (clr_active_q) begin
			x_wr = '{en: 1'b1, addr: clr_idx_q, value: 1'b0};
			y_wr = '{en: 1'b1, addr: clr_idx_q, value: 1'b0};
		end else begin
			x_wr = '{en: flag_set, addr: x_row_s1, value: 1'b1};
			y_wr = '{en: flag_set, addr: y_row_s1, value: 1'b1};
		end
	end

	gpmc_flag_mem #(
		.DEPTH (X_DEPTH)
	) u_x_flags (
		.clk     (clk),
		.rd_en   (item_fire),
		.rd_addr (item.x_row),
		.rd_data (x_flag_rd),
		.wr      (x_wr)
	);

	gpmc_flag_mem #(
		.DEPTH (Y_DEPTH)
	) u_y_flags (
		.clk     (clk),
		.rd_en   (item_fire),
		.rd_addr (item.y_row),
		.rd_data (y_flag_rd),
		.wr      (y_wr)
	);

	// column stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// column stage payload; forward a flag set in the same cycle as the read
	always_ff @(posedge clk) begin
		if (item_fire) begin
			x_row_s1  <= item.x_row;
			y_row_s1  <= item.y_row;
			x_code_s1 <= item.x_code;
			y_code_s1 <= item.y_code;
			last_s1   <= item.last_column;
			x_fwd_s1  <= flag_set && (x_row_s1 == item.x_row);
			y_fwd_s1  <= flag_set && (y_row_s1 == item.y_row);
		end
	end

	// running counts, cleared at the end of each pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compared_q <= '0;
			mismatch_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				compared_q <= '0;
				mismatch_q <= '0;
			end else begin
				compared_q <= compared_new;
				mismatch_q <= mismatch_new;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_x_q   <= x_row_s1;
			out_y_q   <= y_row_s1;
			out_mis_q <= mismatch_new;
			out_cmp_q <= compared_new;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.match_x_row = out_x_q;
	assign result.match_y_row = out_y_q;
	assign result.mismatches  = out_mis_q;
	assign result.compared    = out_cmp_q;

endmodule

@@ sv/gpmc_checker.sv @@
// ----------------------------------------------------------------------------
// gpmc_checker
// Port-level checks on the genotype pair mismatch counter, bound to the core.
// ----------------------------------------------------------------------------
module gpmc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_ready,
	input logic           result_valid,
	input logic           result_ready,
	input gpmc_pkg::row_t result_x,
	input gpmc_pkg::row_t result_y,
	input gpmc_pkg::cnt_t result_mis,
	input gpmc_pkg::cnt_t result_cmp,
	input logic           cfg_valid,
	input logic           cfg_ready
);
	import gpmc_pkg::*;

	// a held result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
		$stable(result_x) && $stable(result_y) && $stable(result_mis) &&
		$stable(result_cmp))
		else $error("result payload changed while stalled");

	// register writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

	// flag sweep holds off column requests right after reset
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !item_ready && !result_valid)
		else $error("request taken before flag sweep");

endmodule

bind genotype_pair_mismatch_counter_core gpmc_checker u_gpmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_x     (result.match_x_row),
	.result_y     (result.match_y_row),
	.result_mis   (result.mismatches),
	.result_cmp   (result.compared),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);
